[hdl/ubxd_pkg.sv]
// Shared types, constants and helpers for the UBX byte-stream deframer.
package ubxd_pkg;

  // Input operation codes.
  localparam logic OP_DATA  = 1'b0;
  localparam logic OP_BREAK = 1'b1;

  // Sync pair and frame layout.
  localparam logic [7:0] SYNC_FIRST     = 8'hB5;
  localparam logic [7:0] SYNC_SECOND    = 8'h62;
  localparam logic [1:0] HEADER_LAST    = 2'd3;
  localparam logic [1:0] HEADER_LEN_LO  = 2'd2;
  localparam int         CHECKSUM_BYTES = 2;

  typedef enum logic [1:0] {
    PH_HUNT   = 2'd0,
    PH_SYNC1  = 2'd1,
    PH_HEADER = 2'd2,
    PH_BODY   = 2'd3
  } phase_t;

  // One result word as it leaves the parser.
  typedef struct packed {
    logic        valid;
    logic [7:0]  frame_byte;
    logic        first_of_frame;
    logic        last_of_frame;
    logic        aborted;
    logic [15:0] discarded_count;
  } result_t;

  // Saturating increment of the discard counter.
  function automatic logic [15:0] sat_inc(input logic [15:0] value);
    logic [15:0] r;
    r = (value == 16'hFFFF) ? value : value + 16'd1;
    return r;
  endfunction

endpackage

[hdl/ubx_frame_deframer_core.sv]
// Top level of the UBX byte-stream deframer: parser plus output register and skid stage.
//
// The block takes one received word per clock cycle while in_ready is high:
// either a data byte or a stream break. It hunts for the sync pair 0xB5 0x62,
// then passes on the four header bytes, the payload whose little-endian length
// sits in header bytes 2 and 3, and the two checksum bytes, marking the first
// and the last word of the frame. The first header word carries the number of
// bytes thrown away while hunting (saturating at 65535). A break inside a
// frame yields a single word with aborted set and all other fields zero; a
// break while hunting yields nothing. Every input word is handled in the cycle
// it is accepted, so the sustained rate is one word per cycle while in_ready is
// high, and its result is registered in the output or skid register. The state
// update of the parser is the only loop. Results sit in an output register
// backed by a one-word skid register, so input stays open while one result
// waits to be taken; in_ready falls only when both are full.
module ubx_frame_deframer_core (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        op,
  input  logic [7:0]  data_byte,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [7:0]  frame_byte,
  output logic        first_of_frame,
  output logic        last_of_frame,
  output logic        aborted,
  output logic [15:0] discarded_count
);

  ubxd_pkg::result_t res;
  ubxd_pkg::result_t out_word;
  ubxd_pkg::result_t skid_word;
  logic              skid_valid;
  logic              step;
  logic              res_valid;

  // An input word is taken whenever the skid register is free.
  assign in_ready  = !skid_valid;
  assign step      = in_valid && in_ready;
  assign res_valid = res.valid;

  ubxd_parser u_parser (
    .clk       (clk),
    .rst       (rst),
    .step      (step),
    .op        (op),
    .data_byte (data_byte),
    .res       (res)
  );

  // Valid flags of the output and skid registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (!out_valid || out_ready) begin
      if (skid_valid) begin
        out_valid  <= 1'b1;
        skid_valid <= res_valid;
      end else begin
        out_valid  <= res_valid;
      end
    end else if (res_valid) begin
      skid_valid <= 1'b1;
    end
  end

  // Payload of the output and skid registers; no reset needed.
  always_ff @(posedge clk) begin
    if (!out_valid || out_ready) begin
      if (skid_valid) begin
        out_word  <= skid_word;
        skid_word <= res;
      end else begin
        out_word  <= res;
      end
    end else if (res_valid) begin
      skid_word <= res;
    end
  end

  assign frame_byte      = out_word.frame_byte;
  assign first_of_frame  = out_word.first_of_frame;
  assign last_of_frame   = out_word.last_of_frame;
  assign aborted         = out_word.aborted;
  assign discarded_count = out_word.discarded_count;

`ifndef ASSERT_OFF
  a_skid_behind_out: assert property (@(posedge clk) disable iff (rst)
    skid_valid |-> out_valid)
    else $error("skid register full while output register empty");

  a_stall_to_skid: assert property (@(posedge clk) disable iff (rst)
    (res_valid && out_valid && !out_ready) |=> skid_valid)
    else $error("result lost while output stalled");

  a_skid_drains: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_ready && skid_valid) |=> out_valid)
    else $error("skid word not moved to output");
`endif

endmodule

[hdl/ubxd_parser.sv]
// Sync hunt and frame tracking state of the UBX deframer, one word per step.
module ubxd_parser (
  input  logic              clk,
  input  logic              rst,
  input  logic              step,
  input  logic              op,
  input  logic [7:0]        data_byte,
  output ubxd_pkg::result_t res
);

  ubxd_pkg::phase_t phase, phase_next;
  logic [1:0]       header_index, header_index_next;
  logic [7:0]       length_low, length_low_next;
  logic [16:0]      bytes_remaining, bytes_remaining_next;
  logic [15:0]      discard_counter, discard_counter_next;

  logic [15:0] count_once;
  logic [15:0] count_twice;
  logic [16:0] remaining_dec;

  assign count_once    = ubxd_pkg::sat_inc(discard_counter);
  assign count_twice   = ubxd_pkg::sat_inc(count_once);
  assign remaining_dec = (bytes_remaining != 17'd0) ? bytes_remaining - 17'd1 : 17'd0;

  // Next state.
  always_comb begin
    phase_next           = phase;
    header_index_next    = header_index;
    length_low_next      = length_low;
    bytes_remaining_next = bytes_remaining;
    discard_counter_next = discard_counter;
    if (step) begin
      if (op == ubxd_pkg::OP_BREAK) begin
        phase_next           = ubxd_pkg::PH_HUNT;
        header_index_next    = 2'd0;
        length_low_next      = 8'd0;
        bytes_remaining_next = 17'd0;
        discard_counter_next = 16'd0;
      end else begin
        unique case (phase)
          ubxd_pkg::PH_HUNT: begin
            if (data_byte == ubxd_pkg::SYNC_FIRST) begin
              phase_next = ubxd_pkg::PH_SYNC1;
            end else begin
              discard_counter_next = count_once;
            end
          end
          ubxd_pkg::PH_SYNC1: begin
            if (data_byte == ubxd_pkg::SYNC_SECOND) begin
              phase_next        = ubxd_pkg::PH_HEADER;
              header_index_next = 2'd0;
            end else if (data_byte == ubxd_pkg::SYNC_FIRST) begin
              discard_counter_next = count_once;
            end else begin
              discard_counter_next = count_twice;
              phase_next           = ubxd_pkg::PH_HUNT;
            end
          end
          ubxd_pkg::PH_HEADER: begin
            if (header_index == 2'd0) begin
              discard_counter_next = 16'd0;
            end
            if (header_index == ubxd_pkg::HEADER_LEN_LO) begin
              length_low_next = data_byte;
            end
            if (header_index == ubxd_pkg::HEADER_LAST) begin
              bytes_remaining_next = {1'b0, data_byte, length_low}
                                     + 17'(ubxd_pkg::CHECKSUM_BYTES);
              header_index_next    = 2'd0;
              phase_next           = ubxd_pkg::PH_BODY;
            end else begin
              header_index_next = header_index + 2'd1;
            end
          end
          ubxd_pkg::PH_BODY: begin
            bytes_remaining_next = remaining_dec;
            if (remaining_dec == 17'd0) begin
              phase_next        = ubxd_pkg::PH_HUNT;
              header_index_next = 2'd0;
            end
          end
          default: begin
            phase_next = ubxd_pkg::PH_HUNT;
          end
        endcase
      end
    end
  end

  // Result of the current word.
  always_comb begin
    res = '0;
    if (step) begin
      if (op == ubxd_pkg::OP_BREAK) begin
        res.valid   = (phase == ubxd_pkg::PH_HEADER) || (phase == ubxd_pkg::PH_BODY);
        res.aborted = res.valid;
      end else begin
        unique case (phase)
          ubxd_pkg::PH_HEADER: begin
            res.valid          = 1'b1;
            res.frame_byte     = data_byte;
            res.first_of_frame = (header_index == 2'd0);
            if (header_index == 2'd0) begin
              res.discarded_count = discard_counter;
            end
          end
          ubxd_pkg::PH_BODY: begin
            res.valid         = 1'b1;
            res.frame_byte    = data_byte;
            res.last_of_frame = (remaining_dec == 17'd0);
          end
          default: begin
            res = '0;
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase           <= ubxd_pkg::PH_HUNT;
      header_index    <= 2'd0;
      length_low      <= 8'd0;
      bytes_remaining <= 17'd0;
      discard_counter <= 16'd0;
    end else begin
      phase           <= phase_next;
      header_index    <= header_index_next;
      length_low      <= length_low_next;
      bytes_remaining <= bytes_remaining_next;
      discard_counter <= discard_counter_next;
    end
  end

`ifndef ASSERT_OFF
  a_break_restarts: assert property (@(posedge clk) disable iff (rst)
    (step && op == ubxd_pkg::OP_BREAK) |=>
      (phase == ubxd_pkg::PH_HUNT && discard_counter == 16'd0))
    else $error("break did not restart the hunt");

  a_first_clears_count: assert property (@(posedge clk) disable iff (rst)
    (res.valid && res.first_of_frame) |=> (discard_counter == 16'd0))
    else $error("discard count not cleared after first header byte");

  a_abort_clean: assert property (@(posedge clk) disable iff (rst)
    res.aborted |-> (res.frame_byte == 8'd0 && !res.first_of_frame &&
                     !res.last_of_frame && res.discarded_count == 16'd0))
    else $error("aborted word carries data");

  a_body_index: assert property (@(posedge clk) disable iff (rst)
    (phase == ubxd_pkg::PH_BODY) |-> (header_index == 2'd0 && bytes_remaining != 17'd0))
    else $error("body phase with stale header index or no bytes left");
`endif

endmodule

[sim/ubx_frame_deframer_core_test.sv]
// Self-checking testbench for the UBX byte-stream deframer core.
module ubx_frame_deframer_core_test;

  timeunit 1ns;
  timeprecision 1ps;

  // One word offered on the input channel: a data byte or a stream break.
  typedef struct packed {
    logic       op_code;
    logic [7:0] value;
  } link_word_t;

  // One word expected on the output channel.
  typedef struct packed {
    logic [7:0]  frame_byte;
    logic        first_of_frame;
    logic        last_of_frame;
    logic        aborted;
    logic [15:0] discarded_count;
  } frame_word_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic        op = ubxd_pkg::OP_DATA;
  logic [7:0]  data_byte = 8'h00;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [7:0]  frame_byte;
  logic        first_of_frame;
  logic        last_of_frame;
  logic        aborted;
  logic [15:0] discarded_count;

  // Words still to be offered, and frame words still owed by the block.
  link_word_t  pending_words[$];
  frame_word_t expected_words[$];
  int          words_built = 0;
  int          fail_count = 0;

  // Percentages of cycles in which the sender idles and the receiver stalls.
  int sender_idle_pct = 0;
  int sink_stall_pct = 0;

  // Shadow copy of the deframer state, kept in step with accepted words.
  ubxd_pkg::phase_t parse_phase = ubxd_pkg::PH_HUNT;
  logic [1:0]       hdr_pos = 2'd0;
  logic [7:0]       len_lo = 8'h00;
  logic [16:0]      body_left = 17'd0;
  logic [15:0]      discards = 16'd0;

  ubx_frame_deframer_core DUT (
    .clk             (clk),
    .rst             (rst),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .op              (op),
    .data_byte       (data_byte),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .frame_byte      (frame_byte),
    .first_of_frame  (first_of_frame),
    .last_of_frame   (last_of_frame),
    .aborted         (aborted),
    .discarded_count (discarded_count)
  );

  always #4 clk = ~clk;

  // The hunting discard count stops at its ceiling rather than wrapping.
  task count_dropped();
    if (discards != 16'hFFFF) begin
      discards = discards + 16'd1;
    end
  endtask

  // Advances the shadow state by one accepted word and queues any frame word
  // that the block owes for it.
  task automatic track_deframer(input logic word_op, input logic [7:0] b);
    frame_word_t w;
    w = '0;
    if (word_op == ubxd_pkg::OP_BREAK) begin
      // A break only produces a word when it cuts a frame short.
      if (parse_phase == ubxd_pkg::PH_HEADER || parse_phase == ubxd_pkg::PH_BODY) begin
        w.aborted = 1'b1;
        expected_words.insert(expected_words.size(), w);
      end
      parse_phase = ubxd_pkg::PH_HUNT;
      hdr_pos = 2'd0;
      len_lo = 8'h00;
      body_left = 17'd0;
      discards = 16'd0;
    end else begin
      case (parse_phase)
        ubxd_pkg::PH_HUNT: begin
          if (b == ubxd_pkg::SYNC_FIRST) begin
            parse_phase = ubxd_pkg::PH_SYNC1;
          end else begin
            count_dropped();
          end
        end
        ubxd_pkg::PH_SYNC1: begin
          if (b == ubxd_pkg::SYNC_SECOND) begin
            parse_phase = ubxd_pkg::PH_HEADER;
            hdr_pos = 2'd0;
          end else begin
            // The earlier first sync byte is lost either way; a further 0xB5
            // takes its place, anything else is lost as well.
            count_dropped();
            if (b != ubxd_pkg::SYNC_FIRST) begin
              count_dropped();
              parse_phase = ubxd_pkg::PH_HUNT;
            end
          end
        end
        ubxd_pkg::PH_HEADER: begin
          w.frame_byte = b;
          if (hdr_pos == 2'd0) begin
            w.first_of_frame = 1'b1;
            w.discarded_count = discards;
            discards = 16'd0;
          end
          if (hdr_pos == ubxd_pkg::HEADER_LEN_LO) begin
            len_lo = b;
          end
          if (hdr_pos == ubxd_pkg::HEADER_LAST) begin
            body_left = {1'b0, b, len_lo} + 17'(ubxd_pkg::CHECKSUM_BYTES);
            hdr_pos = 2'd0;
            parse_phase = ubxd_pkg::PH_BODY;
          end else begin
            hdr_pos = hdr_pos + 2'd1;
          end
          expected_words.insert(expected_words.size(), w);
        end
        default: begin
          w.frame_byte = b;
          if (body_left != 17'd0) begin
            body_left = body_left - 17'd1;
          end
          if (body_left == 17'd0) begin
            w.last_of_frame = 1'b1;
            parse_phase = ubxd_pkg::PH_HUNT;
            hdr_pos = 2'd0;
          end
          expected_words.insert(expected_words.size(), w);
        end
      endcase
    end
  endtask

  task automatic push_word(input logic code, input logic [7:0] v);
    link_word_t w;
    w.op_code = code;
    w.value = v;
    pending_words.insert(pending_words.size(), w);
    words_built++;
  endtask

  // Queues a sync pair, a header carrying the given length, the payload and
  // the checksum, all with random content. When cut is not negative, a break
  // replaces the frame from that byte after the sync pair onwards.
  task automatic push_frame(input int len, input int cut);
    logic [15:0] len_bits;
    len_bits = 16'(len);
    push_word(ubxd_pkg::OP_DATA, ubxd_pkg::SYNC_FIRST);
    push_word(ubxd_pkg::OP_DATA, ubxd_pkg::SYNC_SECOND);
    for (int i = 0; i < len + 6; i++) begin
      if (i == cut) begin
        push_word(ubxd_pkg::OP_BREAK, 8'($urandom_range(255)));
        return;
      end
      if (i == 2) begin
        push_word(ubxd_pkg::OP_DATA, len_bits[7:0]);
      end else if (i == 3) begin
        push_word(ubxd_pkg::OP_DATA, len_bits[15:8]);
      end else begin
        push_word(ubxd_pkg::OP_DATA, 8'($urandom_range(255)));
      end
    end
  endtask

  // Payload lengths are mostly short, with the odd one crossing into the
  // high length byte.
  function automatic int pick_length();
    int r;
    r = $urandom_range(99);
    if (r < 80) begin
      return $urandom_range(8);
    end else if (r < 95) begin
      return $urandom_range(64, 9);
    end
    case ($urandom_range(2))
      0: return 255;
      1: return 256;
      default: return 511;
    endcase
  endfunction

  // Random traffic: mostly well-formed frames behind a little line noise,
  // with truncated frames, false sync starts, breaks and noise bursts mixed in.
  task automatic build_traffic(input int n);
    int target;
    int choice;
    int len;
    target = words_built + n;
    while (words_built < target) begin
      choice = $urandom_range(99);
      if (choice < 60) begin
        repeat ($urandom_range(3)) push_word(ubxd_pkg::OP_DATA, 8'($urandom_range(255)));
        if ($urandom_range(9) == 0) begin
          push_word(ubxd_pkg::OP_DATA, ubxd_pkg::SYNC_FIRST);
        end
        push_frame(pick_length(), -1);
      end else if (choice < 75) begin
        len = $urandom_range(8);
        push_frame(len, $urandom_range(len + 5));
      end else if (choice < 85) begin
        push_word(ubxd_pkg::OP_DATA, ubxd_pkg::SYNC_FIRST);
        push_word(ubxd_pkg::OP_DATA, 8'($urandom_range(255)));
      end else if (choice < 93) begin
        if ($urandom_range(1) == 1) begin
          push_word(ubxd_pkg::OP_DATA, ubxd_pkg::SYNC_FIRST);
        end
        push_word(ubxd_pkg::OP_BREAK, 8'($urandom_range(255)));
      end else begin
        repeat ($urandom_range(10, 1)) begin
          push_word(ubxd_pkg::OP_DATA, 8'($urandom_range(255)));
        end
      end
    end
  endtask

  // Holds the sender off until every queued word has gone in and every owed
  // frame word has come out, then lets the clock run on so that nothing is
  // still in flight.
  task drain();
    while (!(pending_words.size() == 0 && !in_valid && expected_words.size() == 0)) begin
      @(posedge clk);
    end
    repeat (4) @(posedge clk);
  endtask

  // Driver. Inputs change only through nonblocking assignments at the rising
  // edge, and the handshake is sampled at the same edge, so both sides see
  // the values from before the edge. A held word is never touched until it
  // has been accepted, and in_valid gets a single assignment per edge.
  always @(posedge clk) begin : drive_link
    link_word_t nxt;
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        track_deframer(op, data_byte);
      end
      if (!in_valid || in_ready) begin
        if (pending_words.size() != 0 && $urandom_range(99) >= sender_idle_pct) begin
          nxt = pending_words.pop_front();
          in_valid <= 1'b1;
          op <= nxt.op_code;
          data_byte <= nxt.value;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Monitor. Each frame word taken from the block is checked against the
  // oldest word still owed; a word with nothing owed is an error too.
  always @(posedge clk) begin : watch_frames
    frame_word_t want;
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (expected_words.size() == 0) begin
          $error("unexpected word: frame_byte %02h aborted %0b", frame_byte, aborted);
          fail_count++;
        end else begin
          want = expected_words.pop_front();
          if (frame_byte !== want.frame_byte) begin
            $error("frame_byte: expected %02h, got %02h", want.frame_byte, frame_byte);
            fail_count++;
          end
          if (first_of_frame !== want.first_of_frame) begin
            $error("first_of_frame: expected %0b, got %0b",
                   want.first_of_frame, first_of_frame);
            fail_count++;
          end
          if (last_of_frame !== want.last_of_frame) begin
            $error("last_of_frame: expected %0b, got %0b",
                   want.last_of_frame, last_of_frame);
            fail_count++;
          end
          if (aborted !== want.aborted) begin
            $error("aborted: expected %0b, got %0b", want.aborted, aborted);
            fail_count++;
          end
          if (discarded_count !== want.discarded_count) begin
            $error("discarded_count: expected %0d, got %0d",
                   want.discarded_count, discarded_count);
            fail_count++;
          end
        end
      end
      out_ready <= ($urandom_range(99) >= sink_stall_pct);
    end
  end

  initial begin : stimulus
    logic [7:0] v;

    // Directed opening. Two noise bytes at the value extremes, then a false
    // first sync (0xB5 followed by something other than 0x62), then a
    // repeated first sync, which leaves five bytes counted as discarded.
    push_word(ubxd_pkg::OP_DATA, 8'h00);
    push_word(ubxd_pkg::OP_DATA, 8'hFF);
    push_word(ubxd_pkg::OP_DATA, ubxd_pkg::SYNC_FIRST);
    push_word(ubxd_pkg::OP_DATA, 8'h00);
    push_word(ubxd_pkg::OP_DATA, ubxd_pkg::SYNC_FIRST);
    push_word(ubxd_pkg::OP_DATA, ubxd_pkg::SYNC_FIRST);
    push_word(ubxd_pkg::OP_DATA, ubxd_pkg::SYNC_SECOND);
    // Zero-length frame: header, then straight into the two checksum bytes.
    push_word(ubxd_pkg::OP_DATA, 8'hFF);
    push_word(ubxd_pkg::OP_DATA, 8'h00);
    push_word(ubxd_pkg::OP_DATA, 8'h00);
    push_word(ubxd_pkg::OP_DATA, 8'h00);
    push_word(ubxd_pkg::OP_DATA, 8'hFF);
    push_word(ubxd_pkg::OP_DATA, 8'h00);
    // The next frame must report a count of zero, since the last one cleared
    // it. A break after its payload, before its checksum, then drops it as aborted.
    push_word(ubxd_pkg::OP_DATA, ubxd_pkg::SYNC_FIRST);
    push_word(ubxd_pkg::OP_DATA, ubxd_pkg::SYNC_SECOND);
    push_word(ubxd_pkg::OP_DATA, 8'h01);
    push_word(ubxd_pkg::OP_DATA, 8'h02);
    push_word(ubxd_pkg::OP_DATA, 8'h01);
    push_word(ubxd_pkg::OP_DATA, 8'h00);
    push_word(ubxd_pkg::OP_DATA, ubxd_pkg::SYNC_FIRST);
    push_word(ubxd_pkg::OP_BREAK, 8'hFF);
    // A break while waiting for the second sync byte yields nothing.
    push_word(ubxd_pkg::OP_DATA, ubxd_pkg::SYNC_FIRST);
    push_word(ubxd_pkg::OP_BREAK, 8'h00);

    // A long noise burst runs the discard count well up; a frame reports it
    // and the one straight after reports zero.
    repeat (200) begin
      v = 8'($urandom_range(255));
      if (v == ubxd_pkg::SYNC_FIRST) begin
        v = 8'h00;
      end
      push_word(ubxd_pkg::OP_DATA, v);
    end
    push_frame(3, -1);
    push_frame(0, -1);
    build_traffic(450);

    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // Phase one runs flat out; then the sender idles, then the receiver
    // stalls, then both do a little. Each phase drains completely before the
    // next, which also pauses the sender until nothing is owed.
    drain();
    sender_idle_pct = 74;
    build_traffic(450);
    drain();
    sender_idle_pct = 0;
    sink_stall_pct = 74;
    build_traffic(450);
    drain();
    sender_idle_pct = 13;
    sink_stall_pct = 13;
    build_traffic(450);
    drain();

    // Keep the receiver open for a while so that any stray word is caught.
    sink_stall_pct = 0;
    repeat (8) @(posedge clk);
    if (fail_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  // Watchdog, several times the slowest expected run.
  initial begin : watchdog
    #10_000_000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
